@@ sv/face_tangent_generator_defines.svh @@
// assertion macros for the face tangent generator checker
// no dependencies; included by ftg_checker.sv
`ifndef FACE_TANGENT_GENERATOR_DEFINES_SVH
`define FACE_TANGENT_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define FTG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ftg check failed");

// next-cycle implication, sampled on clock, off during reset
`define FTG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ftg check failed");

`endif

@@ sv/ftg_pkg.sv @@
// shared types and constants of the face tangent generator
// no dependencies; used by ftg_isqrt, ftg_div and the top level
`default_nettype none
package ftg_pkg;

   localparam int IDX_W  = 10;
   localparam int POS_W  = 32;
   localparam int TEX_W  = 16;
   localparam int TAN_W  = 16;
   localparam int RAD_W  = 62;
   localparam int ROOT_W = 31;
   localparam int NUM_W  = 45;
   localparam int QUO_W  = 15;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic signed [TEX_W-1:0] u;
      logic signed [TEX_W-1:0] v;
   } vertex_type;

   localparam int VTX_W = $bits(vertex_type);

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_RD_D,
      ST_DIFF,
      ST_MUL,
      ST_SIGN,
      ST_SHIFT,
      ST_SQ,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

@@ sv/ftg_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module ftg_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/ftg_isqrt.sv @@
// iterative integer square root, two radicand bits per cycle
// depends on ftg_pkg
`default_nettype none
module ftg_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ftg_pkg::RAD_W-1:0]     radicand,
   output ftg_pkg::unit_stat_type        stat,
   output logic [ftg_pkg::ROOT_W-1:0]    root
);

   logic [ftg_pkg::RAD_W-1:0]  n_ff, n_in;
   logic [ftg_pkg::ROOT_W+3:0] rem_ff, rem_in;
   logic [ftg_pkg::ROOT_W-1:0] res_ff, res_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [ftg_pkg::ROOT_W+3:0] rem_sh, trial;
   logic                       ge;

   always_comb begin
      rem_sh  = {rem_ff[ftg_pkg::ROOT_W+1:0], n_ff[ftg_pkg::RAD_W-1 -: 2]};
      trial   = {2'b00, res_ff, 2'b01};
      ge      = rem_sh >= trial;
      n_in    = n_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = radicand;
         rem_in  = '0;
         res_in  = '0;
         cnt_in  = 5'(ftg_pkg::ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in   = {n_ff[ftg_pkg::RAD_W-3:0], 2'b00};
         rem_in = ge ? rem_sh - trial : rem_sh;
         res_in = {res_ff[ftg_pkg::ROOT_W-2:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = res_ff;

endmodule
`default_nettype wire

@@ sv/ftg_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on ftg_pkg; quotient known to stay below 2^QUO_W
`default_nettype none
module ftg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ftg_pkg::NUM_W-1:0]     num,
   input  logic [ftg_pkg::ROOT_W-1:0]    den,
   output ftg_pkg::unit_stat_type        stat,
   output logic [ftg_pkg::QUO_W-1:0]     quot
);

   logic [ftg_pkg::ROOT_W-1:0] rem_ff, rem_in;
   logic [ftg_pkg::ROOT_W-1:0] den_ff, den_in;
   logic [ftg_pkg::QUO_W-1:0]  sh_ff, sh_in;
   logic [ftg_pkg::QUO_W-1:0]  q_ff, q_in;
   logic [3:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [ftg_pkg::ROOT_W:0]   rem_sh, rem_sub;
   logic                       ge;

   always_comb begin
      rem_sh  = {rem_ff, sh_ff[ftg_pkg::QUO_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = ftg_pkg::ROOT_W'(num[ftg_pkg::NUM_W-1:ftg_pkg::QUO_W]);
         sh_in   = num[ftg_pkg::QUO_W-1:0];
         den_in  = den;
         q_in    = '0;
         cnt_in  = 4'(ftg_pkg::QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[ftg_pkg::ROOT_W-1:0] : rem_sh[ftg_pkg::ROOT_W-1:0];
         sh_in  = {sh_ff[ftg_pkg::QUO_W-2:0], 1'b0};
         q_in   = {q_ff[ftg_pkg::QUO_W-2:0], ge};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;

endmodule
`default_nettype wire

@@ sv/face_tangent_generator.sv @@
// top level of the face tangent generator: sequencer, multiply datapath, vertex ram
// depends on ftg_pkg, ftg_ram, ftg_isqrt, ftg_div
// A load request (mode 0) writes one vertex into the vertex ram and gives no response. A
// triangle request (mode 1) is worked on alone: the block raises req_stall until its three
// responses (one per corner, same tangent) have been taken. A triangle goes through the ram
// reads of its three corners, the differences, eight products through one shared 17x33
// multiplier, the sign step, the scaling, the three squares, the square root, one divider run
// per component and the three responses, which can be held by rsp_stall. A zero det goes
// straight to the responses and a zero length skips the divider. The vertex ram has no reset;
// reading a vertex that was never loaded gives undefined tangents. Corner indices at or above
// MAX_VERTICES read as a zero vertex and loads to them are dropped.
`default_nettype none
module face_tangent_generator #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [9:0]  req_vertex_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_tex_u,
   input  logic signed [15:0] req_tex_v,
   input  logic [9:0]  req_second_index,
   input  logic [9:0]  req_third_index,
   input  logic        req_end_of_mesh,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_corner_index,
   output logic signed [15:0] rsp_tangent_x,
   output logic signed [15:0] rsp_tangent_y,
   output logic signed [15:0] rsp_tangent_z,
   output logic        rsp_handed_negative,
   output logic        rsp_degenerate,
   output logic        rsp_last_corner,
   output logic        rsp_mesh_done
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam logic [31:0] MAXV = 32'(MAX_VERTICES);
   localparam int IW = ftg_pkg::IDX_W;

   ftg_pkg::state_type state_ff, state_in;

   logic [IW-1:0]          idx_ff [3];
   logic [IW-1:0]          idx_in [3];
   logic                   ok_ff [3];
   logic                   ok_in [3];
   logic                   eom_ff, eom_in;
   ftg_pkg::vertex_type    vtx_ff [3];
   ftg_pkg::vertex_type    vtx_in [3];
   logic signed [32:0]     e1_ff [3];
   logic signed [32:0]     e1_in [3];
   logic signed [32:0]     e2_ff [3];
   logic signed [32:0]     e2_in [3];
   logic signed [16:0]     du1_ff, du1_in, dv1_ff, dv1_in;
   logic signed [16:0]     du2_ff, du2_in, dv2_ff, dv2_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic signed [49:0]     prod_ff, prod_in;
   logic signed [34:0]     det_ff, det_in;
   logic signed [50:0]     c_ff [3];
   logic signed [50:0]     c_in [3];
   logic [50:0]            a_ff [3];
   logic [50:0]            a_in [3];
   logic                   sgn_ff [3];
   logic                   sgn_in [3];
   logic                   neg_ff, neg_in;
   logic                   degen_ff, degen_in;
   logic [59:0]            sq_ff, sq_in;
   logic [ftg_pkg::RAD_W-1:0]  l2_ff, l2_in;
   logic [ftg_pkg::ROOT_W-1:0] len_ff, len_in;
   logic [ftg_pkg::QUO_W-1:0]  q_ff [3];
   logic [ftg_pkg::QUO_W-1:0]  q_in [3];

   logic signed [16:0]     op_a;
   logic signed [32:0]     op_b;
   logic [29:0]            a_sel;
   logic                   wide;
   logic [IW-1:0]          rd_idx;
   logic [AW+IW-1:0]       rd_ext, wr_ext;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic                   wr_en;
   logic [ftg_pkg::VTX_W-1:0] rd_data;
   ftg_pkg::vertex_type    wr_vtx;
   logic                   sqrt_start, div_start;
   ftg_pkg::unit_stat_type sqrt_stat, div_stat;
   logic [ftg_pkg::ROOT_W-1:0] sqrt_root;
   logic [ftg_pkg::QUO_W-1:0]  div_quot;
   logic [ftg_pkg::NUM_W-1:0]  div_num;
   logic signed [ftg_pkg::TAN_W-1:0] tan [3];

   // vertex ram
   assign wr_vtx  = '{x: req_pos_x, y: req_pos_y, z: req_pos_z, u: req_tex_u, v: req_tex_v};
   assign wr_ext  = {{AW{1'b0}}, req_vertex_index};
   assign wr_addr = wr_ext[AW-1:0];
   assign rd_ext  = {{AW{1'b0}}, rd_idx};
   assign rd_addr = rd_ext[AW-1:0];
   assign wr_en   = (state_ff == ftg_pkg::ST_IDLE) && req_valid && !req_mode
                    && (32'(req_vertex_index) < MAXV);

   ftg_ram #(
      .WIDTH (ftg_pkg::VTX_W),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_vtx),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ftg_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (l2_ff),
      .stat     (sqrt_stat),
      .root     (sqrt_root)
   );

   ftg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (len_ff),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // operand selection for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cnt_ff)
         4'd0: begin op_a = du1_ff; op_b = 33'(dv2_ff); end
         4'd1: begin op_a = du2_ff; op_b = 33'(dv1_ff); end
         4'd2: begin op_a = dv2_ff; op_b = e1_ff[0]; end
         4'd3: begin op_a = dv1_ff; op_b = e2_ff[0]; end
         4'd4: begin op_a = dv2_ff; op_b = e1_ff[1]; end
         4'd5: begin op_a = dv1_ff; op_b = e2_ff[1]; end
         4'd6: begin op_a = dv2_ff; op_b = e1_ff[2]; end
         4'd7: begin op_a = dv1_ff; op_b = e2_ff[2]; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    a_sel = a_ff[0][29:0];
         2'd1:    a_sel = a_ff[1][29:0];
         2'd2:    a_sel = a_ff[2][29:0];
         default: a_sel = '0;
      endcase
   end

   assign wide    = (|a_ff[0][50:30]) | (|a_ff[1][50:30]) | (|a_ff[2][50:30]);
   assign div_num = {1'b0, a_sel, 14'b0} + {15'b0, len_ff[ftg_pkg::ROOT_W-1:1]};

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ok_in    = ok_ff;
      eom_in   = eom_ff;
      vtx_in   = vtx_ff;
      e1_in    = e1_ff;
      e2_in    = e2_ff;
      du1_in   = du1_ff;
      dv1_in   = dv1_ff;
      du2_in   = du2_ff;
      dv2_in   = dv2_ff;
      cnt_in   = cnt_ff;
      prod_in  = op_a * op_b;
      det_in   = det_ff;
      c_in     = c_ff;
      a_in     = a_ff;
      sgn_in   = sgn_ff;
      neg_in   = neg_ff;
      degen_in = degen_ff;
      sq_in    = a_sel * a_sel;
      l2_in    = l2_ff;
      len_in   = len_ff;
      q_in     = q_ff;
      rd_idx     = idx_ff[0];
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      case (state_ff)
         ftg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid && req_mode) begin
               idx_in[0] = req_vertex_index;
               idx_in[1] = req_second_index;
               idx_in[2] = req_third_index;
               ok_in[0]  = 32'(req_vertex_index) < MAXV;
               ok_in[1]  = 32'(req_second_index) < MAXV;
               ok_in[2]  = 32'(req_third_index) < MAXV;
               eom_in    = req_end_of_mesh;
               state_in  = ftg_pkg::ST_RD_A;
            end
         end
         ftg_pkg::ST_RD_A: begin
            rd_idx   = idx_ff[0];
            state_in = ftg_pkg::ST_RD_B;
         end
         ftg_pkg::ST_RD_B: begin
            rd_idx    = idx_ff[1];
            vtx_in[0] = ok_ff[0] ? ftg_pkg::vertex_type'(rd_data) : '0;
            state_in  = ftg_pkg::ST_RD_C;
         end
         ftg_pkg::ST_RD_C: begin
            rd_idx    = idx_ff[2];
            vtx_in[1] = ok_ff[1] ? ftg_pkg::vertex_type'(rd_data) : '0;
            state_in  = ftg_pkg::ST_RD_D;
         end
         ftg_pkg::ST_RD_D: begin
            vtx_in[2] = ok_ff[2] ? ftg_pkg::vertex_type'(rd_data) : '0;
            state_in  = ftg_pkg::ST_DIFF;
         end
         ftg_pkg::ST_DIFF: begin
            e1_in[0] = 33'(vtx_ff[1].x) - 33'(vtx_ff[0].x);
            e1_in[1] = 33'(vtx_ff[1].y) - 33'(vtx_ff[0].y);
            e1_in[2] = 33'(vtx_ff[1].z) - 33'(vtx_ff[0].z);
            e2_in[0] = 33'(vtx_ff[2].x) - 33'(vtx_ff[0].x);
            e2_in[1] = 33'(vtx_ff[2].y) - 33'(vtx_ff[0].y);
            e2_in[2] = 33'(vtx_ff[2].z) - 33'(vtx_ff[0].z);
            du1_in   = 17'(vtx_ff[1].u) - 17'(vtx_ff[0].u);
            dv1_in   = 17'(vtx_ff[1].v) - 17'(vtx_ff[0].v);
            du2_in   = 17'(vtx_ff[2].u) - 17'(vtx_ff[0].u);
            dv2_in   = 17'(vtx_ff[2].v) - 17'(vtx_ff[0].v);
            cnt_in   = '0;
            state_in = ftg_pkg::ST_MUL;
         end
         ftg_pkg::ST_MUL: begin
            // accumulate the product issued in the previous cycle
            case (cnt_ff)
               4'd1: det_in = prod_ff[34:0];
               4'd2: det_in = det_ff - prod_ff[34:0];
               4'd3: c_in[0] = 51'(prod_ff);
               4'd4: c_in[0] = c_ff[0] - 51'(prod_ff);
               4'd5: c_in[1] = 51'(prod_ff);
               4'd6: c_in[1] = c_ff[1] - 51'(prod_ff);
               4'd7: c_in[2] = 51'(prod_ff);
               4'd8: c_in[2] = c_ff[2] - 51'(prod_ff);
               default: det_in = det_ff;
            endcase
            if (cnt_ff == 4'd8) begin
               cnt_in   = '0;
               state_in = ftg_pkg::ST_SIGN;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ftg_pkg::ST_SIGN: begin
            for (int k = 0; k < 3; k++) begin
               a_in[k]   = c_ff[k][50] ? 51'(-c_ff[k]) : 51'(c_ff[k]);
               sgn_in[k] = c_ff[k][50] ^ det_ff[34];
            end
            neg_in   = !det_ff[34] && (det_ff != '0);
            degen_in = det_ff == '0;
            cnt_in   = '0;
            state_in = (det_ff == '0) ? ftg_pkg::ST_EMIT : ftg_pkg::ST_SHIFT;
         end
         ftg_pkg::ST_SHIFT: begin
            if (wide) begin
               for (int k = 0; k < 3; k++) begin
                  a_in[k] = a_ff[k] >> 1;
               end
            end else begin
               cnt_in   = '0;
               l2_in    = '0;
               state_in = ftg_pkg::ST_SQ;
            end
         end
         ftg_pkg::ST_SQ: begin
            if (cnt_ff != 4'd0) begin
               l2_in = l2_ff + ftg_pkg::RAD_W'(sq_ff);
            end
            if (cnt_ff == 4'd3) begin
               state_in = ftg_pkg::ST_SQRT_GO;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ftg_pkg::ST_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = ftg_pkg::ST_SQRT_WAIT;
         end
         ftg_pkg::ST_SQRT_WAIT: begin
            if (sqrt_stat.done) begin
               len_in = sqrt_root;
               cnt_in = '0;
               if (sqrt_root == '0) begin
                  degen_in = 1'b1;
                  state_in = ftg_pkg::ST_EMIT;
               end else begin
                  state_in = ftg_pkg::ST_DIV_GO;
               end
            end
         end
         ftg_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ftg_pkg::ST_DIV_WAIT;
         end
         ftg_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               case (cnt_ff[1:0])
                  2'd0:    q_in[0] = div_quot;
                  2'd1:    q_in[1] = div_quot;
                  default: q_in[2] = div_quot;
               endcase
               if (cnt_ff == 4'd2) begin
                  cnt_in   = '0;
                  state_in = ftg_pkg::ST_EMIT;
               end else begin
                  cnt_in   = cnt_ff + 4'd1;
                  state_in = ftg_pkg::ST_DIV_GO;
               end
            end
         end
         ftg_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (cnt_ff == 4'd2) begin
                  cnt_in   = '0;
                  state_in = ftg_pkg::ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         default: state_in = ftg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ftg_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff   <= idx_in;
      ok_ff    <= ok_in;
      eom_ff   <= eom_in;
      vtx_ff   <= vtx_in;
      e1_ff    <= e1_in;
      e2_ff    <= e2_in;
      du1_ff   <= du1_in;
      dv1_ff   <= dv1_in;
      du2_ff   <= du2_in;
      dv2_ff   <= dv2_in;
      prod_ff  <= prod_in;
      det_ff   <= det_in;
      c_ff     <= c_in;
      a_ff     <= a_in;
      sgn_ff   <= sgn_in;
      neg_ff   <= neg_in;
      degen_ff <= degen_in;
      sq_ff    <= sq_in;
      l2_ff    <= l2_in;
      len_ff   <= len_in;
      q_ff     <= q_in;
   end

   // response fields
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (degen_ff) begin
            tan[k] = '0;
         end else if (sgn_ff[k]) begin
            tan[k] = -$signed({1'b0, q_ff[k]});
         end else begin
            tan[k] = $signed({1'b0, q_ff[k]});
         end
      end
   end

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    rsp_corner_index = idx_ff[0];
         2'd1:    rsp_corner_index = idx_ff[1];
         default: rsp_corner_index = idx_ff[2];
      endcase
   end

   assign rsp_tangent_x       = tan[0];
   assign rsp_tangent_y       = tan[1];
   assign rsp_tangent_z       = tan[2];
   assign rsp_handed_negative = neg_ff;
   assign rsp_degenerate      = degen_ff;
   assign rsp_last_corner     = cnt_ff == 4'd2;
   assign rsp_mesh_done       = (cnt_ff == 4'd2) && eom_ff;

endmodule
`default_nettype wire

@@ sv/ftg_checker.sv @@
// port-level checker for the face tangent generator, bound to the top level
// depends on face_tangent_generator_defines.svh and face_tangent_generator
`default_nettype none
`include "face_tangent_generator_defines.svh"
module ftg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [9:0]  rsp_corner_index,
   input logic signed [15:0] rsp_tangent_x,
   input logic signed [15:0] rsp_tangent_y,
   input logic signed [15:0] rsp_tangent_z,
   input logic        rsp_degenerate,
   input logic        rsp_last_corner,
   input logic        rsp_mesh_done
);

   `FTG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_corner_index) && $stable(rsp_tangent_x))
   `FTG_ASSERT_NOW(a_degen_zero, rsp_valid && rsp_degenerate, (rsp_tangent_x == 16'sd0) && (rsp_tangent_y == 16'sd0) && (rsp_tangent_z == 16'sd0))
   `FTG_ASSERT_NOW(a_done_last, rsp_valid && rsp_mesh_done, rsp_last_corner)
   `FTG_ASSERT_NOW(a_busy_emit, rsp_valid, req_stall)

endmodule

bind face_tangent_generator ftg_checker u_ftg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_corner_index (rsp_corner_index),
   .rsp_tangent_x    (rsp_tangent_x),
   .rsp_tangent_y    (rsp_tangent_y),
   .rsp_tangent_z    (rsp_tangent_z),
   .rsp_degenerate   (rsp_degenerate),
   .rsp_last_corner  (rsp_last_corner),
   .rsp_mesh_done    (rsp_mesh_done)
);
`default_nettype wire
